@@ rtl/core/lav_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lav_pkg;

    localparam int FRAC_BITS = 16;

    localparam int W      = 32;   // Q format word
    localparam int D_W    = W + 1;
    localparam int OP_W   = W + 1;
    localparam int ACC_W  = 2 * OP_W;
    localparam int VEC_W  = 64;
    localparam int DIVC_W = $clog2(FRAC_BITS + 1);

    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // one look-at request after the front end
    typedef struct packed {
        logic [2:0][W-1:0]   eye;
        logic [2:0][W-1:0]   up;
        logic [2:0][D_W-1:0] d;     // look - eye, full width
    } lav_item_t;

    // handshake between queue and back end
    typedef struct packed {
        logic      valid;
        lav_item_t item;
    } lav_qout_t;

endpackage

`default_nettype wire

@@ rtl/core/lav_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lav_front
    import lav_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic signed [W-1:0] eye_x,
    input  wire logic signed [W-1:0] eye_y,
    input  wire logic signed [W-1:0] eye_z,
    input  wire logic signed [W-1:0] look_x,
    input  wire logic signed [W-1:0] look_y,
    input  wire logic signed [W-1:0] look_z,
    input  wire logic signed [W-1:0] up_x,
    input  wire logic signed [W-1:0] up_y,
    input  wire logic signed [W-1:0] up_z,
    output logic                     push,
    output lav_item_t                push_item,
    input  wire logic                q_full
);

    logic      fv_reg;
    lav_item_t item_reg;
    lav_item_t item_next;

    assign in_stall  = fv_reg && q_full;
    assign push      = fv_reg && !q_full;
    assign push_item = item_reg;

    always_comb
    begin
        item_next.eye = {eye_z, eye_y, eye_x};
        item_next.up  = {up_z, up_y, up_x};
        item_next.d[0] = {look_x[W-1], look_x} - {eye_x[W-1], eye_x};
        item_next.d[1] = {look_y[W-1], look_y} - {eye_y[W-1], eye_y};
        item_next.d[2] = {look_z[W-1], look_z} - {eye_z[W-1], eye_z};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            fv_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/lav_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lav_queue
    import lav_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire lav_item_t push_item,
    output logic           full,
    input  wire logic      pop,
    output lav_qout_t      qout
);

    lav_item_t       mem_reg [QDEPTH];
    logic [QAW-1:0]  wp_reg;
    logic [QAW-1:0]  rp_reg;
    logic [QCW-1:0]  cnt_reg;
    logic            do_pop;

    assign full       = (cnt_reg == QCW'(QDEPTH));
    assign qout.valid = (cnt_reg != '0);
    assign qout.item  = mem_reg[rp_reg];
    assign do_pop     = pop && qout.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= (wp_reg == QAW'(QDEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (do_pop)
            begin
                rp_reg <= (rp_reg == QAW'(QDEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (!push && do_pop)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/lav_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lav_back
    import lav_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire lav_qout_t  qout,
    output logic            pop,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [1:0]      row_index,
    output logic signed [W-1:0] col0,
    output logic signed [W-1:0] col1,
    output logic signed [W-1:0] col2,
    output logic signed [W-1:0] col3,
    output logic            last_row,
    output logic            degenerate
);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_ABS   = 10'b0000000010,
        ST_NORM  = 10'b0000000100,
        ST_MUL   = 10'b0000001000,
        ST_ACC   = 10'b0000010000,
        ST_POST  = 10'b0000100000,
        ST_SQRT  = 10'b0001000000,
        ST_DINIT = 10'b0010000000,
        ST_DIV   = 10'b0100000000,
        ST_EMIT  = 10'b1000000000
    } state_t;

    typedef enum logic [1:0] {
        JOB_SQ      = 2'd0,
        JOB_CROSS_C = 2'd1,
        JOB_CROSS_Y = 2'd2,
        JOB_DOT     = 2'd3
    } job_t;

    localparam logic signed [W-1:0] ONE_Q    = W'(1) << FRAC_BITS;
    localparam logic [VEC_W-1:0]    SQRT_TOP = VEC_W'(1) << 62;
    localparam logic [ACC_W-1:0]    HALF     = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic [ACC_W-1:0]    POS_LIM  = ACC_W'(32'h7fff_ffff);
    localparam logic [ACC_W-1:0]    NEG_LIM  = ACC_W'(32'h8000_0000);

    function automatic logic [1:0] idx_p1(input logic [1:0] i);
        case (i)
            2'd0:    return 2'd1;
            2'd1:    return 2'd2;
            default: return 2'd0;
        endcase
    endfunction

    function automatic logic [1:0] idx_p2(input logic [1:0] i);
        case (i)
            2'd0:    return 2'd2;
            2'd1:    return 2'd0;
            default: return 2'd1;
        endcase
    endfunction

    // drop FRAC_BITS rounding half away from zero, optional negate, saturate
    function automatic logic signed [W-1:0] rescale_sat(input logic signed [ACC_W-1:0] v,
                                                         input logic flip);
        logic [ACC_W-1:0] m;
        logic [ACC_W-1:0] r;
        logic             neg;
        neg = v[ACC_W-1] ^ flip;
        m   = v[ACC_W-1] ? (~v + 1'b1) : v;
        r   = (m + HALF) >> FRAC_BITS;
        if (!neg)
        begin
            return (r > POS_LIM) ? 32'sh7fff_ffff : r[W-1:0];
        end
        return (r > NEG_LIM) ? 32'sh8000_0000 : W'(~r + 1'b1);
    endfunction

    state_t state_reg, state_next;
    job_t   job_reg;
    logic   pass_reg;           // 0: forming z, 1: forming x
    logic [1:0] elem_reg;
    logic [1:0] term_reg;
    logic   degen_reg;

    logic signed [W-1:0]     eye_reg [3];
    logic signed [W-1:0]     up_reg  [3];
    logic signed [VEC_W-1:0] vec_reg [3];
    logic [VEC_W-1:0]        mag_reg [3];
    logic signed [W-1:0]     z_reg   [3];
    logic signed [W-1:0]     x_reg   [3];
    logic signed [W-1:0]     y_reg   [3];
    logic signed [W-1:0]     t_reg   [3];

    logic signed [ACC_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [VEC_W-1:0] sq_n_reg, sq_res_reg, sq_bit_reg;
    logic [VEC_W-1:0] rem_reg, den_reg;
    logic [W-1:0]     quo_reg;
    logic [DIVC_W-1:0] dcnt_reg;

    logic             ov_reg;
    logic [1:0]       orow_reg;
    logic signed [W-1:0] ocol_reg [4];
    logic             olast_reg;
    logic             odeg_reg;

    logic [VEC_W-1:0] mag_or;
    logic [1:0]       i1, i2, ia, ib;
    logic signed [OP_W-1:0] opa, opb;
    logic             sub_term, last_term;
    logic [VEC_W-1:0] sq_try;
    logic             sq_ge;
    logic             div_ge;
    logic [W-1:0]     qn;
    logic signed [W-1:0] qs;
    logic             emit_ld;

    assign mag_or    = mag_reg[0] | mag_reg[1] | mag_reg[2];
    assign i1        = idx_p1(elem_reg);
    assign i2        = idx_p2(elem_reg);
    assign ia        = term_reg[0] ? i2 : i1;
    assign ib        = term_reg[0] ? i1 : i2;
    assign sub_term  = (job_reg == JOB_CROSS_C || job_reg == JOB_CROSS_Y) && term_reg[0];
    assign last_term = (job_reg == JOB_SQ || job_reg == JOB_DOT) ? (term_reg == 2'd2)
                                                                  : (term_reg == 2'd1);
    assign sq_try    = sq_res_reg + sq_bit_reg;
    assign sq_ge     = (sq_n_reg >= sq_try);
    assign div_ge    = (rem_reg >= den_reg);
    assign qn        = {quo_reg[W-2:0], div_ge};
    assign qs        = vec_reg[elem_reg][VEC_W-1] ? $signed(~qn + 1'b1) : $signed(qn);
    assign emit_ld   = (state_reg == ST_EMIT) && (!ov_reg || !out_stall);
    assign pop       = (state_reg == ST_IDLE) && qout.valid;

    always_comb
    begin
        opa = '0;
        opb = '0;
        case (job_reg)
            JOB_SQ:
            begin
                opa = $signed({3'b000, mag_reg[term_reg][29:0]});
                opb = opa;
            end
            JOB_CROSS_C:
            begin
                opa = {up_reg[ia][W-1], up_reg[ia]};
                opb = {z_reg[ib][W-1], z_reg[ib]};
            end
            JOB_CROSS_Y:
            begin
                opa = {z_reg[ia][W-1], z_reg[ia]};
                opb = {x_reg[ib][W-1], x_reg[ib]};
            end
            JOB_DOT:
            begin
                case (elem_reg)
                    2'd0:    opa = {x_reg[term_reg][W-1], x_reg[term_reg]};
                    2'd1:    opa = {y_reg[term_reg][W-1], y_reg[term_reg]};
                    default: opa = {z_reg[term_reg][W-1], z_reg[term_reg]};
                endcase
                opb = {eye_reg[term_reg][W-1], eye_reg[term_reg]};
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (qout.valid) state_next = ST_ABS;
            ST_ABS:   state_next = ST_NORM;
            ST_NORM:
            begin
                if (mag_or == '0)
                begin
                    state_next = ST_MUL;
                end
                else if (!(|mag_or[VEC_W-1:30]) && mag_or[29])
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:   state_next = ST_ACC;
            ST_ACC:   state_next = last_term ? ST_POST : ST_MUL;
            ST_POST:
            begin
                case (job_reg)
                    JOB_SQ:      state_next = ST_SQRT;
                    JOB_CROSS_C: state_next = (elem_reg == 2'd2) ? ST_ABS : ST_MUL;
                    JOB_DOT:     state_next = (elem_reg == 2'd2) ? ST_EMIT : ST_MUL;
                    default:     state_next = ST_MUL;
                endcase
            end
            ST_SQRT:  if (sq_bit_reg[0]) state_next = ST_DINIT;
            ST_DINIT: state_next = ST_DIV;
            ST_DIV:
            begin
                if (dcnt_reg == '0)
                begin
                    state_next = (elem_reg == 2'd2) ? ST_MUL : ST_DINIT;
                end
            end
            ST_EMIT:  if (emit_ld && elem_reg == 2'd3) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit_ld)
            begin
                ov_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (qout.valid)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        eye_reg[i] <= $signed(qout.item.eye[i]);
                        up_reg[i]  <= $signed(qout.item.up[i]);
                        vec_reg[i] <= VEC_W'($signed(qout.item.d[i]));
                    end
                    degen_reg <= 1'b0;
                    pass_reg  <= 1'b0;
                end
            end
            ST_ABS:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mag_reg[i] <= vec_reg[i][VEC_W-1] ? (~vec_reg[i] + 1'b1) : vec_reg[i];
                end
            end
            ST_NORM:
            begin
                if (mag_or == '0)
                begin
                    // zero length: unit vector is zero, go straight on
                    for (int i = 0; i < 3; i++)
                    begin
                        if (pass_reg) x_reg[i] <= '0;
                        else          z_reg[i] <= '0;
                    end
                    degen_reg <= 1'b1;
                    job_reg   <= pass_reg ? JOB_CROSS_Y : JOB_CROSS_C;
                    elem_reg  <= 2'd0;
                    term_reg  <= 2'd0;
                    acc_reg   <= '0;
                end
                else if (|mag_or[VEC_W-1:30])
                begin
                    for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] >> 1;
                end
                else if (!mag_or[29])
                begin
                    for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] << 1;
                end
                else
                begin
                    job_reg  <= JOB_SQ;
                    term_reg <= 2'd0;
                    acc_reg  <= '0;
                end
            end
            ST_MUL:
            begin
                prod_reg <= opa * opb;
            end
            ST_ACC:
            begin
                acc_reg <= sub_term ? acc_reg - prod_reg : acc_reg + prod_reg;
                if (!last_term) term_reg <= term_reg + 1'b1;
            end
            ST_POST:
            begin
                term_reg <= 2'd0;
                acc_reg  <= '0;
                case (job_reg)
                    JOB_SQ:
                    begin
                        sq_n_reg   <= acc_reg[VEC_W-1:0];
                        sq_res_reg <= '0;
                        sq_bit_reg <= SQRT_TOP;
                    end
                    JOB_CROSS_C:
                    begin
                        vec_reg[elem_reg] <= acc_reg[VEC_W-1:0];
                        if (elem_reg == 2'd2) pass_reg <= 1'b1;
                        elem_reg <= (elem_reg == 2'd2) ? 2'd0 : elem_reg + 1'b1;
                    end
                    JOB_CROSS_Y:
                    begin
                        y_reg[elem_reg] <= rescale_sat(acc_reg, 1'b0);
                        if (elem_reg == 2'd2) job_reg <= JOB_DOT;
                        elem_reg <= (elem_reg == 2'd2) ? 2'd0 : elem_reg + 1'b1;
                    end
                    default:
                    begin
                        t_reg[elem_reg] <= rescale_sat(acc_reg, 1'b1);
                        elem_reg <= (elem_reg == 2'd2) ? 2'd0 : elem_reg + 1'b1;
                    end
                endcase
            end
            ST_SQRT:
            begin
                if (sq_ge)
                begin
                    sq_n_reg   <= sq_n_reg - sq_try;
                    sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                end
                else
                begin
                    sq_res_reg <= sq_res_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
                elem_reg   <= 2'd0;
            end
            ST_DINIT:
            begin
                rem_reg  <= (VEC_W'(mag_reg[elem_reg][29:0]) << FRAC_BITS)
                            + (sq_res_reg >> 1);
                den_reg  <= sq_res_reg << FRAC_BITS;
                quo_reg  <= '0;
                dcnt_reg <= DIVC_W'(FRAC_BITS);
            end
            ST_DIV:
            begin
                if (div_ge) rem_reg <= rem_reg - den_reg;
                den_reg  <= den_reg >> 1;
                quo_reg  <= qn;
                dcnt_reg <= dcnt_reg - 1'b1;
                if (dcnt_reg == '0)
                begin
                    if (pass_reg) x_reg[elem_reg] <= qs;
                    else          z_reg[elem_reg] <= qs;
                    if (elem_reg == 2'd2)
                    begin
                        job_reg  <= pass_reg ? JOB_CROSS_Y : JOB_CROSS_C;
                        elem_reg <= 2'd0;
                        term_reg <= 2'd0;
                        acc_reg  <= '0;
                    end
                    else
                    begin
                        elem_reg <= elem_reg + 1'b1;
                    end
                end
            end
            ST_EMIT:
            begin
                if (emit_ld)
                begin
                    orow_reg  <= elem_reg;
                    olast_reg <= (elem_reg == 2'd3);
                    odeg_reg  <= degen_reg;
                    if (elem_reg == 2'd3)
                    begin
                        ocol_reg[0] <= t_reg[0];
                        ocol_reg[1] <= t_reg[1];
                        ocol_reg[2] <= t_reg[2];
                        ocol_reg[3] <= ONE_Q;
                    end
                    else
                    begin
                        ocol_reg[0] <= x_reg[elem_reg];
                        ocol_reg[1] <= y_reg[elem_reg];
                        ocol_reg[2] <= z_reg[elem_reg];
                        ocol_reg[3] <= '0;
                    end
                    elem_reg <= elem_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid  = ov_reg;
    assign row_index  = orow_reg;
    assign col0       = ocol_reg[0];
    assign col1       = ocol_reg[1];
    assign col2       = ocol_reg[2];
    assign col3       = ocol_reg[3];
    assign last_row   = olast_reg;
    assign degenerate = odeg_reg;

endmodule

`default_nettype wire

@@ rtl/core/look_at_view_matrix_unit.sv @@
// Left-handed look-at view matrix in signed Q16.16. Each word on the input
// channel (eye, target, up) yields four words on the output channel, rows 0
// to 3 in order; last_row marks row 3 and degenerate is repeated on all four
// rows when the view direction or up-cross-view had zero length. An input
// register and a two-word queue take requests while the back end works; the
// back end handles one request at a time with one shared 33x33 multiplier, a
// bit-serial square root, a restoring divider and a normalizer that shifts
// one bit per cycle. Without output stalls, the time a request takes varies
// with the shift counts of the two normalizations; a request whose target
// equals the eye, or whose up is parallel to the view, finishes sooner, as a
// zero-length vector skips its square root and divides. The output register
// lets the next request start as soon as row 3 is loaded.
`timescale 1ns / 1ps
`default_nettype none

module look_at_view_matrix_unit
    import lav_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic signed [W-1:0] eye_x,
    input  wire logic signed [W-1:0] eye_y,
    input  wire logic signed [W-1:0] eye_z,
    input  wire logic signed [W-1:0] look_x,
    input  wire logic signed [W-1:0] look_y,
    input  wire logic signed [W-1:0] look_z,
    input  wire logic signed [W-1:0] up_x,
    input  wire logic signed [W-1:0] up_y,
    input  wire logic signed [W-1:0] up_z,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [1:0]               row_index,
    output logic signed [W-1:0]      col0,
    output logic signed [W-1:0]      col1,
    output logic signed [W-1:0]      col2,
    output logic signed [W-1:0]      col3,
    output logic                     last_row,
    output logic                     degenerate
);

    logic      push;
    lav_item_t push_item;
    logic      q_full;
    logic      pop;
    lav_qout_t qout;

    lav_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .eye_x     (eye_x),
        .eye_y     (eye_y),
        .eye_z     (eye_z),
        .look_x    (look_x),
        .look_y    (look_y),
        .look_z    (look_z),
        .up_x      (up_x),
        .up_y      (up_y),
        .up_z      (up_z),
        .push      (push),
        .push_item (push_item),
        .q_full    (q_full)
    );

    lav_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .qout      (qout)
    );

    lav_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .qout       (qout),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .row_index  (row_index),
        .col0       (col0),
        .col1       (col1),
        .col2       (col2),
        .col3       (col3),
        .last_row   (last_row),
        .degenerate (degenerate)
    );

endmodule

`default_nettype wire
